/* hw/rtl/xrs_pkg.sv */
// Package for the xoroshiro64** range generator: types, constants and the
// state step functions. It depends on nothing else.
`timescale 1ns / 1ps
package xrs_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned DATA_W = 128;
    localparam int unsigned USER_W = 2;
    localparam int unsigned CNT_W  = 5;

    localparam logic [WORD_W-1:0] SEED_OFS_P = 32'd193;
    localparam logic [WORD_W-1:0] SEED_OFS_Q = 32'd7771;
    localparam logic [WORD_W-1:0] MIX_PA     = 32'd522133279;
    localparam logic [WORD_W-1:0] MIX_QA     = 32'd93444155;
    localparam logic [WORD_W-1:0] MIX_PB     = 32'd720880126;
    localparam logic [WORD_W-1:0] MIX_QB     = 32'd1665791465;
    localparam logic [WORD_W-1:0] SCRAMBLE_K = 32'h9e3779bb;

    typedef enum logic [1:0] {
        ACT_RESEED = 2'd0,
        ACT_DRAW   = 2'd1,
        ACT_RANGED = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_A0,
        ST_MIX_A1,
        ST_MIX_B0,
        ST_MIX_B1,
        ST_ADVANCE,
        ST_SCRAMBLE,
        ST_MOD,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_P_A,
        MUL_Q_A,
        MUL_P_B,
        MUL_Q_B,
        MUL_SCRAMBLE
    } t_mul_sel;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_WORD,
        OUT_RANGED
    } t_out_sel;

    typedef struct packed {
        logic     load_in;
        t_mul_sel mul_sel;
        logic     mix_acc;
        logic     mix_a;
        logic     mix_b;
        logic     advance;
        logic     scramble;
        logic     mod_step;
        logic     out_load;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic span_zero;
        logic mod_last;
    } t_dp_status;

    function automatic logic [WORD_W-1:0] f_next_a(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] x;
        x = a ^ b;
        return {a[5:0], a[31:6]} ^ x ^ (x << 9);
    endfunction

    function automatic logic [WORD_W-1:0] f_next_b(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] x;
        x = a ^ b;
        return {x[18:0], x[31:19]};
    endfunction

    function automatic logic [WORD_W-1:0] f_mixed_a();
        logic [WORD_W-1:0] p;
        logic [WORD_W-1:0] q;
        p = SEED_OFS_P;
        q = SEED_OFS_Q;
        return (p * MIX_PA) ^ (q * MIX_QA);
    endfunction

    function automatic logic [WORD_W-1:0] f_mixed_b();
        logic [WORD_W-1:0] p;
        logic [WORD_W-1:0] q;
        p = SEED_OFS_P;
        q = SEED_OFS_Q;
        return (p * MIX_PB) ^ (q * MIX_QB);
    endfunction

    localparam logic [WORD_W-1:0] RESET_A = f_next_a(f_mixed_a(), f_mixed_b());
    localparam logic [WORD_W-1:0] RESET_B = f_next_b(f_mixed_a(), f_mixed_b());

endpackage

/* hw/rtl/xrs_datapath.sv */
// Datapath of the range generator: state words, the shared multiplier,
// the bit-serial remainder unit and the output data register. Uses xrs_pkg.
`timescale 1ns / 1ps
module xrs_datapath
    import xrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DATA_W-1:0] i_data,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    output logic [WORD_W-1:0] o_value
);

    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_p;
    logic [WORD_W-1:0] r_q;
    logic [WORD_W-1:0] r_lo;
    logic [WORD_W-1:0] r_span;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_prod;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_out;

    logic [WORD_W-1:0] w_seed_first;
    logic [WORD_W-1:0] w_seed_second;
    logic [WORD_W-1:0] w_range_low;
    logic [WORD_W-1:0] w_range_high;
    logic [WORD_W-1:0] w_op_x;
    logic [WORD_W-1:0] w_op_k;
    logic [WORD_W-1:0] w_mul;
    logic [WORD_W:0]   w_trial;
    logic [WORD_W:0]   w_diff;
    logic [WORD_W-1:0] w_value;

    assign w_seed_first  = i_data[WORD_W-1:0];
    assign w_seed_second = i_data[2*WORD_W-1:WORD_W];
    assign w_range_low   = i_data[3*WORD_W-1:2*WORD_W];
    assign w_range_high  = i_data[4*WORD_W-1:3*WORD_W];

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_P_A: begin
                w_op_x = r_p;
                w_op_k = MIX_PA;
            end
            MUL_Q_A: begin
                w_op_x = r_q;
                w_op_k = MIX_QA;
            end
            MUL_P_B: begin
                w_op_x = r_p;
                w_op_k = MIX_PB;
            end
            MUL_Q_B: begin
                w_op_x = r_q;
                w_op_k = MIX_QB;
            end
            default: begin
                w_op_x = r_a;
                w_op_k = SCRAMBLE_K;
            end
        endcase
    end

    assign w_mul   = w_op_x * w_op_k;
    assign w_trial = {r_rem, r_word[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_span};

    always_comb begin
        case (i_cmd.out_sel)
            OUT_ZERO:   w_value = '0;
            OUT_WORD:   w_value = r_word;
            OUT_RANGED: w_value = r_lo + r_rem;
            default:    w_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= RESET_A;
            r_b <= RESET_B;
        end else begin
            if (i_cmd.mix_a) begin
                r_a <= r_acc ^ w_mul;
            end
            if (i_cmd.mix_b) begin
                r_b <= r_acc ^ w_mul;
            end
            if (i_cmd.advance) begin
                r_a <= f_next_a(r_a, r_b);
                r_b <= f_next_b(r_a, r_b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_p    <= w_seed_first + SEED_OFS_P;
            r_q    <= w_seed_second + SEED_OFS_Q;
            r_lo   <= w_range_low;
            r_span <= w_range_high - w_range_low + 32'd1;
        end
        if (i_cmd.mix_acc) begin
            r_acc <= w_mul;
        end
        if (i_cmd.advance) begin
            r_prod <= w_mul;
        end
        if (i_cmd.scramble) begin
            r_word <= {r_prod[26:0], r_prod[31:27]} + {r_prod[24:0], r_prod[31:27], 2'b00};
            r_rem  <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.mod_step) begin
            r_word <= {r_word[WORD_W-2:0], 1'b0};
            r_cnt  <= r_cnt + 1'b1;
            if (w_trial >= {1'b0, r_span}) begin
                r_rem <= w_diff[WORD_W-1:0];
            end else begin
                r_rem <= w_trial[WORD_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out <= w_value;
        end
    end

    assign o_status.span_zero = (r_span == '0);
    assign o_status.mod_last  = (r_cnt == {CNT_W{1'b1}});
    assign o_value            = r_out;

endmodule

/* hw/rtl/xrs_controller.sv */
// Controller of the range generator: sequences reseed, draw and remainder
// steps and owns the output valid flag. Uses xrs_pkg.
`timescale 1ns / 1ps
module xrs_controller
    import xrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [USER_W-1:0] i_in_action,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  t_dp_status        i_status,
    output t_dp_cmd           o_cmd
);

    t_state   r_state;
    t_state   n_state;
    t_action  r_action;
    t_action  n_action;
    t_out_sel r_out_sel;
    t_out_sel n_out_sel;
    logic     r_out_valid;
    logic     n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_action    <= ACT_NOP;
            r_out_sel   <= OUT_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_action    <= n_action;
            r_out_sel   <= n_out_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_action      = r_action;
        n_out_sel     = r_out_sel;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_SCRAMBLE;
        o_cmd.out_sel = r_out_sel;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_action      = t_action'(i_in_action);
                    case (t_action'(i_in_action))
                        ACT_RESEED: begin
                            n_state   = ST_MIX_A0;
                            n_out_sel = OUT_ZERO;
                        end
                        ACT_DRAW: begin
                            n_state   = ST_ADVANCE;
                            n_out_sel = OUT_WORD;
                        end
                        ACT_RANGED: begin
                            n_state   = ST_ADVANCE;
                            n_out_sel = OUT_RANGED;
                        end
                        default: begin
                            n_state   = ST_DONE;
                            n_out_sel = OUT_ZERO;
                        end
                    endcase
                end
            end
            ST_MIX_A0: begin
                o_cmd.mul_sel = MUL_P_A;
                o_cmd.mix_acc = 1'b1;
                n_state       = ST_MIX_A1;
            end
            ST_MIX_A1: begin
                o_cmd.mul_sel = MUL_Q_A;
                o_cmd.mix_a   = 1'b1;
                n_state       = ST_MIX_B0;
            end
            ST_MIX_B0: begin
                o_cmd.mul_sel = MUL_P_B;
                o_cmd.mix_acc = 1'b1;
                n_state       = ST_MIX_B1;
            end
            ST_MIX_B1: begin
                o_cmd.mul_sel = MUL_Q_B;
                o_cmd.mix_b   = 1'b1;
                n_state       = ST_ADVANCE;
            end
            ST_ADVANCE: begin
                o_cmd.advance = 1'b1;
                if (r_action == ACT_RESEED) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCRAMBLE;
                end
            end
            ST_SCRAMBLE: begin
                o_cmd.scramble = 1'b1;
                if (r_action == ACT_RANGED && !i_status.span_zero) begin
                    n_state = ST_MOD;
                end else begin
                    n_state   = ST_DONE;
                    n_out_sel = OUT_WORD;
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/xoroshiro64ss_range_generator.sv */
// Top level of the xoroshiro64** range generator: joins the controller and
// the datapath. Uses xrs_pkg, xrs_controller and xrs_datapath.
//
// Each request on the slave stream carries an action in tuser and the seed
// and range words in tdata. A reseed mixes the seed words into the state
// and advances it once; it returns zero. A draw returns the scrambled state
// word and advances the state. A ranged draw returns low plus the word
// modulo (high - low + 1), wrapping mod 2^32; a zero span returns the word.
// Action code 3 leaves the state alone and returns zero.
// Every request gives exactly one result word on the master stream.
// One request is worked on at a time, so the next request is not taken
// until the result of the last one is in the output register. The ranged
// draw runs a 32-step bit-serial remainder loop after the scramble step.
// A new request is accepted while the previous result is still waiting.
// If the receiver stalls, the finished result waits in the datapath
// until the output register is free, and no further request is accepted.
// Synchronous reset puts the state as after a reseed with zero seeds.
`timescale 1ns / 1ps
module xoroshiro64ss_range_generator
    import xrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // seed_first, seed_second, range_low, range_high
    input  logic [DATA_W-1:0] s_axis_tdata,
    // action
    input  logic [USER_W-1:0] s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // value
    output logic [WORD_W-1:0] m_axis_tdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    xrs_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    xrs_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (s_axis_tdata),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_value  (m_axis_tdata)
    );

endmodule
